/* src/lati_pkg.sv */
// Shared types, constants and build-time table functions for the log-add unit.
// No dependencies; every other file imports this package.
package lati_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] log_word_t;

  localparam log_word_t NEG_INF_CODE = 32'sh8000_0000;
  localparam log_word_t LOG_MAX      = 32'sh7FFF_FFFF;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  typedef struct packed {
    logic mul;
    logic sub;
    logic fix;
  } cdiv_en_t;

  function automatic longint unsigned lati_udiv(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned part;
    quo  = '0;
    part = '0;
    for (int k = 63; k >= 0; k--) begin
      part = (part << 1) | ((num >> k) & 64'd1);
      if (part >= den) begin
        part = part - den;
        quo  = quo | (64'd1 << k);
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned lati_exp_neg_q30(input longint unsigned r);
    longint unsigned acc;
    longint unsigned term;
    logic            done;
    acc  = Q30_ONE;
    term = Q30_ONE;
    done = 1'b0;
    for (int n = 1; n < 40; n++) begin
      if (!done) begin
        term = lati_udiv((term * r) >> 30, 64'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((n & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned lati_log1p_q30(input longint unsigned e);
    longint unsigned s;
    longint unsigned s2;
    longint unsigned part;
    longint unsigned acc;
    if (e == 64'd0) begin
      return 64'd0;
    end
    s    = lati_udiv(e << 30, (Q30_ONE << 1) + e);
    s2   = (s * s) >> 30;
    part = s;
    acc  = '0;
    for (int n = 1; n < 100; n += 2) begin
      if (part != 64'd0) begin
        acc  = acc + lati_udiv(part, 64'(n));
        part = (part * s2) >> 30;
      end
    end
    return acc << 1;
  endfunction

  // Entry idx of the correction table: log(1 + exp(x)) over [-thresh, 0].
  function automatic logic [31:0] lati_rom_entry(input int idx, input int size,
                                                 input int thresh, input int frac);
    longint unsigned span;
    longint unsigned num;
    longint unsigned u;
    longint unsigned k;
    longint unsigned r;
    longint unsigned e;
    longint unsigned v;
    span = 64'(size - 1);
    num  = (64'(thresh) * (span - 64'(idx))) << 30;
    u    = lati_udiv(num + (span >> 1), span);
    k    = u / LN2_Q30;
    r    = u - k * LN2_Q30;
    e    = lati_exp_neg_q30(r);
    e    = (k >= 64'd62) ? 64'd0 : (e >> k);
    v    = lati_log1p_q30(e);
    return 32'((v + (64'd1 << (29 - frac))) >> (30 - frac));
  endfunction

endpackage

/* src/lati_in_if.sv */
// Input channel: one word carries the two log-domain operands.
// Depends on lati_pkg for the word type.
interface lati_in_if import lati_pkg::*; ();
  logic      valid;
  logic      ready;
  log_word_t log_a;
  log_word_t log_b;

  modport source (output valid, output log_a, output log_b, input ready);
  modport sink   (input valid, input log_a, input log_b, output ready);
endinterface

/* src/lati_out_if.sv */
// Result channel: one word carries the log sum and the saturation flag.
// Depends on lati_pkg for the word type.
interface lati_out_if import lati_pkg::*; ();
  logic      valid;
  logic      ready;
  log_word_t log_sum;
  logic      saturated;

  modport source (output valid, output log_sum, output saturated, input ready);
  modport sink   (input valid, input log_sum, input saturated, output ready);
endinterface

/* src/log_add_table_interpolated.sv */
// Log-add unit (max-star): log_sum = log(exp(log_a) + exp(log_b)), signed Q15.16 words.
// Depends on lati_pkg, lati_in_if, lati_out_if, lati_cdiv and lati_rom.
//
// in_ch takes one operand word per cycle (valid/ready); out_ch returns one result
// word per operand word, in order. The most negative code is log zero and passes
// the other operand through. The correction term is read from a table at two
// neighboring entries and interpolated linearly; the sum saturates at the top code
// and raises saturated.
// The datapath is a 15-stage pipeline with two constant dividers and a dual-read
// table; throughput is one word per cycle while out_ch does not stall.
// Each stage moves whenever it or any later stage is empty or out_ch is ready, so
// in_ch stays ready until every stage holds a word while out_ch is stalled.
// Reset clears all stage valid bits; no word is in flight after reset and the
// table needs no fill time.
module log_add_table_interpolated import lati_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int THRESHOLD  = 50,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lati_in_if.sink       in_ch,
  lati_out_if.source    out_ch
);

  localparam int T_VAL   = THRESHOLD << FRAC_BITS;
  localparam int T_W     = $clog2(T_VAL + 1);
  localparam int N_W     = $clog2(TABLE_SIZE);
  localparam int I_W     = T_W + N_W;
  localparam int X1_W    = I_W - FRAC_BITS;
  localparam int R_W     = $clog2(THRESHOLD);
  localparam int Q1_W    = X1_W - R_W + 1;
  localparam int Q2_W    = T_W - R_W + 1;
  localparam int P_W     = FRAC_BITS + T_W;
  localparam int TAG1_W  = 1 + WORD_W + FRAC_BITS;
  localparam int TAG2_W  = 1 + WORD_W;
  localparam logic [T_W-1:0] T_C      = T_W'(T_VAL);
  localparam logic [T_W-1:0] HALF_T   = T_W'(T_VAL / 2);
  localparam logic [N_W-1:0] LAST_IDX = N_W'(TABLE_SIZE - 1);

  localparam int ST_IN   = 0;
  localparam int ST_DIFF = 1;
  localparam int ST_OFF  = 2;
  localparam int ST_IDX  = 3;
  localparam int ST_D1A  = 4;
  localparam int ST_D1B  = 5;
  localparam int ST_D1C  = 6;
  localparam int ST_ADDR = 7;
  localparam int ST_ROM  = 8;
  localparam int ST_PROD = 9;
  localparam int ST_ACC  = 10;
  localparam int ST_D2A  = 11;
  localparam int ST_D2B  = 12;
  localparam int ST_D2C  = 13;
  localparam int ST_OUT  = 14;
  localparam int NS      = 15;

  // stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;
  logic [NS-1:0] prev;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      rdy[k] = out_ch.ready | (|(~v_r >> k));
    end
    prev  = {v_r[NS-2:0], in_ch.valid};
    v_nxt = (rdy & prev) | (~rdy & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = rdy[ST_IN];
  assign out_ch.valid = v_r[ST_OUT];

  // input register
  log_word_t a_r;
  log_word_t b_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_IN]) begin
      a_r <= in_ch.log_a;
      b_r <= in_ch.log_b;
    end
  end

  // larger operand, distance, log-zero pass-through
  logic [WORD_W:0] dab;
  logic [WORD_W:0] dba;
  logic            a_ge;
  logic            za;
  logic            zb;
  log_word_t       big_nxt;
  logic [WORD_W-1:0] diff_nxt;
  log_word_t       big2_r;
  logic [WORD_W-1:0] diff2_r;
  logic            lz2_r;

  assign dab      = {a_r[WORD_W-1], a_r} - {b_r[WORD_W-1], b_r};
  assign dba      = {b_r[WORD_W-1], b_r} - {a_r[WORD_W-1], a_r};
  assign a_ge     = ~dab[WORD_W];
  assign za       = (a_r == NEG_INF_CODE);
  assign zb       = (b_r == NEG_INF_CODE);
  assign big_nxt  = za ? b_r : (zb ? a_r : (a_ge ? a_r : b_r));
  assign diff_nxt = a_ge ? dab[WORD_W-1:0] : dba[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) begin
      big2_r  <= big_nxt;
      diff2_r <= diff_nxt;
      lz2_r   <= za | zb;
    end
  end

  // table offset, far-apart bypass
  logic           byp3_nxt;
  log_word_t      big3_r;
  logic           byp3_r;
  logic [T_W-1:0] off3_r;

  assign byp3_nxt = lz2_r | (diff2_r >= WORD_W'(T_VAL));

  always_ff @(posedge clk) begin
    if (rdy[ST_OFF]) begin
      big3_r <= big2_r;
      byp3_r <= byp3_nxt;
      off3_r <= byp3_nxt ? '0 : (T_C - diff2_r[T_W-1:0]);
    end
  end

  // scaled table position
  log_word_t      big4_r;
  logic           byp4_r;
  logic [I_W-1:0] idx4_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_IDX]) begin
      big4_r <= big3_r;
      byp4_r <= byp3_r;
      idx4_r <= I_W'(off3_r) * I_W'(LAST_IDX);
    end
  end

  // split position into entry and weight
  cdiv_en_t            div1_en;
  logic [Q1_W-1:0]     div1_quo;
  logic [R_W-1:0]      div1_rem;
  logic [TAG1_W-1:0]   div1_tag;

  assign div1_en = '{mul: rdy[ST_D1A], sub: rdy[ST_D1B], fix: rdy[ST_D1C]};

  lati_cdiv #(
    .X_W   (X1_W),
    .DIV   (THRESHOLD),
    .TAG_W (TAG1_W)
  ) u_div_idx (
    .clk     (clk),
    .en      (div1_en),
    .x       (idx4_r[I_W-1:FRAC_BITS]),
    .tag_in  ({byp4_r, big4_r, idx4_r[FRAC_BITS-1:0]}),
    .quo     (div1_quo),
    .rem     (div1_rem),
    .tag_out (div1_tag)
  );

  logic [N_W-1:0] i0_nxt;
  logic [N_W-1:0] i0_r;
  logic [N_W-1:0] i1_r;
  logic [T_W-1:0] rem8_r;
  log_word_t      big8_r;
  logic           byp8_r;

  assign i0_nxt = div1_quo[N_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy[ST_ADDR]) begin
      i0_r   <= i0_nxt;
      i1_r   <= (i0_nxt == LAST_IDX) ? i0_nxt : (i0_nxt + N_W'(1));
      rem8_r <= T_W'({div1_rem, div1_tag[FRAC_BITS-1:0]});
      big8_r <= div1_tag[FRAC_BITS +: WORD_W];
      byp8_r <= div1_tag[TAG1_W-1];
    end
  end

  // table read
  logic [FRAC_BITS-1:0] rd0;
  logic [FRAC_BITS-1:0] rd1;
  logic [T_W-1:0]       w0_9_r;
  logic [T_W-1:0]       rem9_r;
  log_word_t            big9_r;
  logic                 byp9_r;

  lati_rom #(
    .TABLE_SIZE (TABLE_SIZE),
    .THRESHOLD  (THRESHOLD),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rom (
    .clk   (clk),
    .en    (rdy[ST_ROM]),
    .addr0 (i0_r),
    .addr1 (i1_r),
    .rd0   (rd0),
    .rd1   (rd1)
  );

  always_ff @(posedge clk) begin
    if (rdy[ST_ROM]) begin
      w0_9_r <= T_C - rem8_r;
      rem9_r <= rem8_r;
      big9_r <= big8_r;
      byp9_r <= byp8_r;
    end
  end

  // weighted entries
  logic [P_W-1:0] p0_r;
  logic [P_W-1:0] p1_r;
  log_word_t      big10_r;
  logic           byp10_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      p0_r    <= P_W'(rd0) * P_W'(w0_9_r);
      p1_r    <= P_W'(rd1) * P_W'(rem9_r);
      big10_r <= big9_r;
      byp10_r <= byp9_r;
    end
  end

  logic [P_W-1:0] acc_r;
  log_word_t      big11_r;
  logic           byp11_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_ACC]) begin
      acc_r   <= p0_r + p1_r + P_W'(HALF_T);
      big11_r <= big10_r;
      byp11_r <= byp10_r;
    end
  end

  // normalize the interpolated sum
  cdiv_en_t           div2_en;
  logic [Q2_W-1:0]    div2_quo;
  logic [TAG2_W-1:0]  div2_tag;

  assign div2_en = '{mul: rdy[ST_D2A], sub: rdy[ST_D2B], fix: rdy[ST_D2C]};

  lati_cdiv #(
    .X_W   (T_W),
    .DIV   (THRESHOLD),
    .TAG_W (TAG2_W)
  ) u_div_corr (
    .clk     (clk),
    .en      (div2_en),
    .x       (acc_r[P_W-1:FRAC_BITS]),
    .tag_in  ({byp11_r, big11_r}),
    .quo     (div2_quo),
    .rem     (),
    .tag_out (div2_tag)
  );

  // add correction, saturate, output register
  log_word_t       big_fin;
  logic [WORD_W:0] sum33;
  logic            ovf;
  log_word_t       out_sum_r;
  logic            out_sat_r;

  assign big_fin = div2_tag[WORD_W-1:0];
  assign sum33   = {big_fin[WORD_W-1], big_fin} + (WORD_W + 1)'(div2_quo[FRAC_BITS-1:0]);
  assign ovf     = (sum33[WORD_W:WORD_W-1] == 2'b01);

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      if (div2_tag[TAG2_W-1]) begin
        out_sum_r <= big_fin;
        out_sat_r <= 1'b0;
      end else if (ovf) begin
        out_sum_r <= LOG_MAX;
        out_sat_r <= 1'b1;
      end else begin
        out_sum_r <= sum33[WORD_W-1:0];
        out_sat_r <= 1'b0;
      end
    end
  end

  assign out_ch.log_sum   = out_sum_r;
  assign out_ch.saturated = out_sat_r;

  a_sat_is_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.log_sum == LOG_MAX)
    else $error("saturated word without top code");

  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_ADDR] |-> (i0_r <= LAST_IDX) && (rem8_r < T_C))
    else $error("table position out of range");

  a_last_entry_exact: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_ADDR] && (i0_r == LAST_IDX) |-> rem8_r == '0)
    else $error("last entry reached with nonzero weight");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_OFF] && !byp3_r |-> (off3_r != '0) && (off3_r <= T_C))
    else $error("table offset outside interpolation span");

endmodule

/* src/lati_cdiv.sv */
// Three-stage divider by a constant: reciprocal multiply, back-multiply, one fixup.
// Carries a tag alongside the operand. Depends on lati_pkg for the enable struct.
module lati_cdiv import lati_pkg::*; #(
  parameter int X_W   = 24,
  parameter int DIV   = 50,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  cdiv_en_t                  en,
  input  logic [X_W-1:0]            x,
  input  logic [TAG_W-1:0]          tag_in,
  output logic [X_W-$clog2(DIV):0]  quo,
  output logic [$clog2(DIV)-1:0]    rem,
  output logic [TAG_W-1:0]          tag_out
);

  localparam int R_W = $clog2(DIV);
  localparam int Q_W = X_W - R_W + 1;
  localparam int E_W = R_W + 1;
  localparam int P_W = X_W + Q_W;
  localparam logic [Q_W-1:0] RECIP = Q_W'((64'd1 << X_W) / DIV);

  logic [P_W-1:0]     prod;
  logic [X_W-1:0]     back;
  logic [E_W-1:0]     rem_raw;

  logic [Q_W-1:0]     est_a_r;
  logic [X_W-1:0]     x_a_r;
  logic [TAG_W-1:0]   tag_a_r;
  logic [Q_W-1:0]     est_b_r;
  logic [E_W-1:0]     rem_b_r;
  logic [TAG_W-1:0]   tag_b_r;
  logic [Q_W-1:0]     quo_r;
  logic [R_W-1:0]     rem_r;
  logic [TAG_W-1:0]   tag_c_r;

  assign prod    = P_W'(x) * P_W'(RECIP);
  assign back    = X_W'((Q_W + R_W)'(est_a_r) * (Q_W + R_W)'(DIV));
  assign rem_raw = E_W'(x_a_r - back);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      est_a_r <= prod[P_W-1:X_W];
      x_a_r   <= x;
      tag_a_r <= tag_in;
    end
    if (en.sub) begin
      est_b_r <= est_a_r;
      rem_b_r <= rem_raw;
      tag_b_r <= tag_a_r;
    end
    if (en.fix) begin
      if (rem_b_r >= E_W'(DIV)) begin
        quo_r <= est_b_r + Q_W'(1);
        rem_r <= R_W'(rem_b_r - E_W'(DIV));
      end else begin
        quo_r <= est_b_r;
        rem_r <= R_W'(rem_b_r);
      end
      tag_c_r <= tag_b_r;
    end
  end

  assign quo     = quo_r;
  assign rem     = rem_r;
  assign tag_out = tag_c_r;

endmodule

/* src/lati_rom.sv */
// Correction table log(1 + exp(x)) with two registered read ports.
// Content is built at elaboration by lati_pkg::lati_rom_entry.
module lati_rom import lati_pkg::*; #(
  parameter int TABLE_SIZE = 1024,
  parameter int THRESHOLD  = 50,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [$clog2(TABLE_SIZE)-1:0] addr0,
  input  logic [$clog2(TABLE_SIZE)-1:0] addr1,
  output logic [FRAC_BITS-1:0]          rd0,
  output logic [FRAC_BITS-1:0]          rd1
);

  logic [FRAC_BITS-1:0] rom_w [TABLE_SIZE];
  logic [FRAC_BITS-1:0] rd0_r;
  logic [FRAC_BITS-1:0] rd1_r;

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
    localparam logic [31:0] ENTRY = lati_rom_entry(g, TABLE_SIZE, THRESHOLD, FRAC_BITS);
    assign rom_w[g] = ENTRY[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r <= rom_w[addr0];
      rd1_r <= rom_w[addr1];
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

/* sim/tb_log_add_table_interpolated.sv */
// Self-checking bench for log_add_table_interpolated: random and corner operand words,
// each result word checked against a bit-exact max-star predictor held in a scoreboard.
// Depends on lati_pkg, lati_in_if, lati_out_if and the block itself.
module tb_log_add_table_interpolated;
  import lati_pkg::*;

  localparam int TABLE_SIZE = 1024;
  localparam int THRESHOLD  = 50;
  localparam int FRAC_BITS  = 16;

  localparam longint T_CODE        = longint'(THRESHOLD) << FRAC_BITS;
  localparam int     WORDS_PER_RUN = 235;
  localparam int     HOLD_CYCLES   = 120;
  localparam int     STALL_LIMIT   = 4000;
  localparam int     SETTLE_CYCLES = 30;

  typedef struct packed {
    log_word_t log_sum;
    logic      saturated;
  } sum_word_t;

  class max_star_scoreboard;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned LOG2_Q30 = 64'd744261118;

    logic [31:0] corr_table[TABLE_SIZE];
    sum_word_t   expected_sums[$];
    int          errors;
    int          shown;
    int          checked;

    function new();
      for (int i = 0; i < TABLE_SIZE; i++) corr_table[i] = table_entry(i);
      errors  = 0;
      shown   = 0;
      checked = 0;
    endfunction

    function longint unsigned exp_neg(longint unsigned r);
      longint unsigned acc;
      longint unsigned term;
      logic            done;
      acc  = ONE_Q30;
      term = ONE_Q30;
      done = 1'b0;
      for (int n = 1; n < 40; n++) begin
        if (!done) begin
          term = ((term * r) >> 30) / longint'(n);
          if (term == 0) done = 1'b1;
          else if (n % 2 == 1) acc -= term;
          else acc += term;
        end
      end
      return acc;
    endfunction

    function longint unsigned log_one_plus(longint unsigned e);
      longint unsigned s;
      longint unsigned s_sq;
      longint unsigned pw;
      longint unsigned acc;
      if (e == 0) return 0;
      s    = (e << 30) / ((ONE_Q30 << 1) + e);
      s_sq = (s * s) >> 30;
      pw   = s;
      acc  = 0;
      for (int n = 1; n < 100; n += 2) begin
        if (pw != 0) begin
          acc += pw / longint'(n);
          pw = (pw * s_sq) >> 30;
        end
      end
      return acc * 2;
    endfunction

    function logic [31:0] table_entry(int i);
      longint unsigned span;
      longint unsigned u;
      longint unsigned k;
      longint unsigned e;
      longint unsigned v;
      span = longint'(TABLE_SIZE - 1);
      u    = (((longint'(THRESHOLD) * (span - longint'(i))) << 30) + span / 2) / span;
      k    = u / LOG2_Q30;
      e    = exp_neg(u - k * LOG2_Q30);
      e    = (k >= 62) ? 0 : (e >> k);
      v    = log_one_plus(e);
      return 32'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    endfunction

    function sum_word_t max_star(log_word_t a, log_word_t b);
      sum_word_t       res;
      longint          big;
      longint          d;
      longint          total;
      longint unsigned tu;
      longint unsigned idx;
      longint unsigned i0;
      longint unsigned i1;
      longint unsigned rem;
      longint unsigned corr;
      res.saturated = 1'b0;
      if (a == NEG_INF_CODE) begin
        res.log_sum = b;
      end else if (b == NEG_INF_CODE) begin
        res.log_sum = a;
      end else begin
        if (a >= b) begin
          big = longint'(a);
          d   = longint'(b) - big;
        end else begin
          big = longint'(b);
          d   = longint'(a) - big;
        end
        if (d <= -T_CODE) begin
          res.log_sum = log_word_t'(big[31:0]);
        end else begin
          tu  = longint'(T_CODE);
          idx = longint'(d + T_CODE) * longint'(TABLE_SIZE - 1);
          i0  = idx / tu;
          rem = idx % tu;
          if (i0 > TABLE_SIZE - 1) i0 = TABLE_SIZE - 1;
          i1   = (i0 + 1 < TABLE_SIZE) ? i0 + 1 : i0;
          corr = (longint'(corr_table[i0]) * (tu - rem) +
                  longint'(corr_table[i1]) * rem + tu / 2) / tu;
          total = big + longint'(corr);
          if (total > longint'(LOG_MAX)) begin
            total         = longint'(LOG_MAX);
            res.saturated = 1'b1;
          end
          res.log_sum = log_word_t'(total[31:0]);
        end
      end
      return res;
    endfunction

    function void note_operands(log_word_t a, log_word_t b);
      expected_sums.push_back(max_star(a, b));
    endfunction

    function void check_sum(log_word_t log_sum, logic saturated);
      sum_word_t want;
      checked++;
      if (expected_sums.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("sum word %0d: unexpected, got %h sat %b", checked, log_sum, saturated);
        end
      end else begin
        want = expected_sums.pop_front();
        if (want.log_sum !== log_sum || want.saturated !== saturated) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("sum word %0d: expected %h sat %b, got %h sat %b", checked,
                     want.log_sum, want.saturated, log_sum, saturated);
          end
        end
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lati_in_if  in_ch ();
  lati_out_if out_ch ();

  log_add_table_interpolated #(
    .TABLE_SIZE (TABLE_SIZE),
    .THRESHOLD  (THRESHOLD),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  max_star_scoreboard sums;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int stall_count   = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sums.check_sum(out_ch.log_sum, out_ch.saturated);
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic log_word_t fit_word(longint v);
    if (v > longint'(LOG_MAX)) return LOG_MAX;
    if (v < -longint'(LOG_MAX)) return -LOG_MAX;
    return log_word_t'(v[31:0]);
  endfunction

  function automatic void pick_operands(output log_word_t a, output log_word_t b);
    int unsigned kind;
    longint      base;
    longint      off;
    kind = $urandom_range(99);
    base = longint'(int'($urandom()));
    off  = longint'($urandom_range(2 * T_CODE + 200)) - (T_CODE + 100);
    if (kind < 50) begin
      a = fit_word(base);
      b = fit_word(base + off);
    end else if (kind < 65) begin
      a = LOG_MAX - log_word_t'($urandom_range(32'h30000));
      b = LOG_MAX - log_word_t'($urandom_range(32'h30000));
    end else if (kind < 83) begin
      a = log_word_t'($urandom());
      b = log_word_t'($urandom());
    end else if (kind < 90) begin
      a = NEG_INF_CODE;
      b = log_word_t'($urandom());
    end else if (kind < 97) begin
      a = log_word_t'($urandom());
      b = NEG_INF_CODE;
    end else if (kind < 99) begin
      a = log_word_t'($urandom());
      b = a;
    end else begin
      a = NEG_INF_CODE;
      b = NEG_INF_CODE;
    end
  endfunction

  task automatic send_word(input log_word_t a, input log_word_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.log_a <= a;
    in_ch.log_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sums.note_operands(a, b);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sums.pending() != 0) @(posedge clk);
  endtask

  initial begin
    log_word_t a;
    log_word_t b;
    sums         = new();
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.log_a  = '0;
    in_ch.log_b  = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(NEG_INF_CODE, NEG_INF_CODE);
    send_word(NEG_INF_CODE, 32'sd5);
    send_word(32'sd7, NEG_INF_CODE);
    send_word(NEG_INF_CODE, LOG_MAX);
    send_word(NEG_INF_CODE + 1, NEG_INF_CODE);
    send_word(32'sd0, 32'sd0);
    send_word(LOG_MAX, LOG_MAX);
    send_word(LOG_MAX, LOG_MAX - 1);
    send_word(NEG_INF_CODE + 1, NEG_INF_CODE + 1);
    send_word(32'sd0, log_word_t'(-T_CODE));
    send_word(32'sd0, log_word_t'(-T_CODE + 1));
    send_word(log_word_t'(-T_CODE + 1), 32'sd0);
    send_word(32'sd0, -32'sd1);
    send_word(LOG_MAX, NEG_INF_CODE + 1);
    send_word(NEG_INF_CODE + 1, LOG_MAX);
    send_word(32'sh1234_5678, 32'sh1233_D678);
    send_word(LOG_MAX - 32'shB172, LOG_MAX - 32'shB172);
    send_word(LOG_MAX - 32'shB173, LOG_MAX - 32'shB173);
    send_word(-32'sh10000, -32'sh18000);
    send_word(32'sh5555_AAAA, 32'sh5555_AAAB);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 29 : 0;
      for (int i = 0; i < WORDS_PER_RUN; i++) begin
        if ((phase == 0 && i == 100) || (phase == 2 && i == 40)) hold_requests++;
        if (phase == 1 && i == 120) wait_drained();
        pick_operands(a, b);
        send_word(a, b);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sums.errors == 0 && sums.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/lati_pkg.sv
src/lati_in_if.sv
src/lati_out_if.sv
src/lati_cdiv.sv
src/lati_rom.sv
src/log_add_table_interpolated.sv
sim/tb_log_add_table_interpolated.sv
